// ===== rtl/core/cau_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the complex arithmetic unit.
package cau_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int WORD_BITS_DEF = 32;

   typedef enum logic [2:0] {
      OP_ADD   = 3'd0,
      OP_SUB   = 3'd1,
      OP_MUL   = 3'd2,
      OP_DIV   = 3'd3,
      OP_CONJ  = 3'd4,
      OP_NEG   = 3'd5,
      OP_SQMAG = 3'd6,
      OP_MAG   = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_SAT  = 2'd1,
      ST_DIVZ = 2'd2
   } status_type;

endpackage

// ===== rtl/core/complex_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// Complex arithmetic unit: add, sub, mul, div, conjugate, negate and magnitudes.
//
// Usage:
//  - req_ channel carries an operation code and two complex operands in
//    signed fixed point (WORD_BITS wide, FRAC_BITS fraction bits). An item
//    is taken when req_valid and req_ready are both high.
//  - rsp_ channel returns one item per request: real part, imaginary part
//    and status (ok, saturated, divide by zero), in request order.
//  - Pipeline: four setup stages (products, sums, rounding/abs, dividend),
//    a divider setup stage, WORD_BITS + 1 bit stages with one quotient and
//    one root bit per stage, and the output register.
//  - Throughput is one item per cycle unless the pipeline is held (below);
//    every operation takes the same path.
//  - When the receiver stalls with a result waiting, the whole pipeline
//    holds and req_ready drops; no item is lost or repeated.
//  - Reset (synchronous, active high) clears all valid bits; items in
//    flight are dropped and the block is ready in the next cycle.
module complex_arithmetic_unit
   import cau_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [2:0]                  req_operation,
   input  logic signed [WORD_BITS-1:0] req_first_re,
   input  logic signed [WORD_BITS-1:0] req_first_im,
   input  logic signed [WORD_BITS-1:0] req_second_re,
   input  logic signed [WORD_BITS-1:0] req_second_im,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [WORD_BITS-1:0] rsp_result_re,
   output logic signed [WORD_BITS-1:0] rsp_result_im,
   output logic [1:0]                  rsp_status
);

   localparam int W  = WORD_BITS;
   localparam int F  = FRAC_BITS;
   localparam int PW = 2 * W;
   localparam int VW = 2 * W + 2;
   localparam int AW = 2 * W;
   localparam int XW = 2 * W;
   localparam int NW = 2 * W + F + 2;
   localparam int DW = 2 * W + 1;
   localparam int RW = DW + 1;
   localparam int TW = 2 * W + 2;
   localparam int K  = W + 1;

   localparam logic signed [VW-1:0] HALF = VW'(1) <<< (F - 1);
   localparam logic signed [VW-1:0] WMAX = {{(VW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [VW-1:0] WMIN = {{(VW-W+1){1'b1}}, {(W-1){1'b0}}};

   function automatic logic [W:0] sat_word(input logic signed [VW-1:0] v);
      if (v > WMAX) begin
         return {1'b1, WMAX[W-1:0]};
      end else if (v < WMIN) begin
         return {1'b1, WMIN[W-1:0]};
      end
      return {1'b0, v[W-1:0]};
   endfunction

   logic en;
   logic out_vld_ff;

   assign en        = ~out_vld_ff | rsp_ready;
   assign req_ready = en;

   // stage 1: products
   logic                 p1_vld_ff;
   op_type               p1_op_ff;
   logic                 p1_zero_ff;
   logic signed [W-1:0]  p1_a_ff, p1_b_ff, p1_c_ff, p1_d_ff;
   logic signed [PW-1:0] p1_ac_ff, p1_bd_ff, p1_ad_ff, p1_bc_ff, p1_s1_ff, p1_s2_ff;
   op_type               p1_op_in;
   logic signed [W-1:0]  p1_sx_in, p1_sy_in;

   always_comb begin
      p1_op_in = op_type'(req_operation);
      p1_sx_in = (p1_op_in == OP_DIV) ? req_second_re : req_first_re;
      p1_sy_in = (p1_op_in == OP_DIV) ? req_second_im : req_first_im;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
      end else if (en) begin
         p1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_op_ff   <= p1_op_in;
         p1_zero_ff <= (req_second_re == '0) && (req_second_im == '0);
         p1_a_ff    <= req_first_re;
         p1_b_ff    <= req_first_im;
         p1_c_ff    <= req_second_re;
         p1_d_ff    <= req_second_im;
         p1_ac_ff   <= req_first_re * req_second_re;
         p1_bd_ff   <= req_first_im * req_second_im;
         p1_ad_ff   <= req_first_re * req_second_im;
         p1_bc_ff   <= req_second_re * req_first_im;
         p1_s1_ff   <= p1_sx_in * p1_sx_in;
         p1_s2_ff   <= p1_sy_in * p1_sy_in;
      end
   end

   // stage 2: sums
   logic                 p2_vld_ff;
   op_type               p2_op_ff;
   logic                 p2_zero_ff;
   logic signed [VW-1:0] p2_re_ff, p2_im_ff, p2_re_in, p2_im_in;
   logic [XW-1:0]        p2_sq_ff, p2_sq_in;

   always_comb begin
      p2_sq_in = XW'($unsigned(p1_s1_ff)) + XW'($unsigned(p1_s2_ff));
      case (p1_op_ff)
         OP_ADD: begin
            p2_re_in = VW'(p1_a_ff) + VW'(p1_c_ff);
            p2_im_in = VW'(p1_b_ff) + VW'(p1_d_ff);
         end
         OP_SUB: begin
            p2_re_in = VW'(p1_a_ff) - VW'(p1_c_ff);
            p2_im_in = VW'(p1_b_ff) - VW'(p1_d_ff);
         end
         OP_MUL: begin
            p2_re_in = VW'(p1_ac_ff) - VW'(p1_bd_ff);
            p2_im_in = VW'(p1_ad_ff) + VW'(p1_bc_ff);
         end
         OP_DIV: begin
            p2_re_in = VW'(p1_ac_ff) + VW'(p1_bd_ff);
            p2_im_in = VW'(p1_bc_ff) - VW'(p1_ad_ff);
         end
         OP_CONJ: begin
            p2_re_in = VW'(p1_a_ff);
            p2_im_in = -VW'(p1_b_ff);
         end
         OP_NEG: begin
            p2_re_in = -VW'(p1_a_ff);
            p2_im_in = -VW'(p1_b_ff);
         end
         default: begin
            p2_re_in = $signed(VW'(p2_sq_in));
            p2_im_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_vld_ff <= 1'b0;
      end else if (en) begin
         p2_vld_ff <= p1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p2_op_ff   <= p1_op_ff;
         p2_zero_ff <= p1_zero_ff;
         p2_re_ff   <= p2_re_in;
         p2_im_ff   <= p2_im_in;
         p2_sq_ff   <= p2_sq_in;
      end
   end

   // stage 3: rounding and dividend magnitude
   logic                 p3_vld_ff;
   op_type               p3_op_ff;
   logic                 p3_zero_ff;
   logic signed [VW-1:0] p3_re_ff, p3_im_ff, p3_re_in, p3_im_in;
   logic [AW-1:0]        p3_are_ff, p3_aim_ff;
   logic                 p3_nre_ff, p3_nim_ff;
   logic [XW-1:0]        p3_sq_ff;

   always_comb begin
      p3_re_in = p2_re_ff;
      p3_im_in = p2_im_ff;
      if (p2_op_ff == OP_MUL || p2_op_ff == OP_SQMAG) begin
         p3_re_in = (p2_re_ff + HALF) >>> F;
         p3_im_in = (p2_im_ff + HALF) >>> F;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_vld_ff <= 1'b0;
      end else if (en) begin
         p3_vld_ff <= p2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p3_op_ff   <= p2_op_ff;
         p3_zero_ff <= p2_zero_ff;
         p3_re_ff   <= p3_re_in;
         p3_im_ff   <= p3_im_in;
         p3_are_ff  <= AW'(p2_re_ff[VW-1] ? -p2_re_ff : p2_re_ff);
         p3_aim_ff  <= AW'(p2_im_ff[VW-1] ? -p2_im_ff : p2_im_ff);
         p3_nre_ff  <= p2_re_ff[VW-1];
         p3_nim_ff  <= p2_im_ff[VW-1];
         p3_sq_ff   <= p2_sq_ff;
      end
   end

   // stage 4: dividend and doubled divisor
   logic                 p4_vld_ff;
   op_type               p4_op_ff;
   logic                 p4_zero_ff;
   logic signed [VW-1:0] p4_re_ff, p4_im_ff;
   logic                 p4_nre_ff, p4_nim_ff;
   logic [XW-1:0]        p4_sq_ff;
   logic [NW-1:0]        p4_dnre_ff, p4_dnim_ff;
   logic [DW-1:0]        p4_den2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_vld_ff <= 1'b0;
      end else if (en) begin
         p4_vld_ff <= p3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p4_op_ff   <= p3_op_ff;
         p4_zero_ff <= p3_zero_ff;
         p4_re_ff   <= p3_re_ff;
         p4_im_ff   <= p3_im_ff;
         p4_nre_ff  <= p3_nre_ff;
         p4_nim_ff  <= p3_nim_ff;
         p4_sq_ff   <= p3_sq_ff;
         p4_dnre_ff <= (NW'(p3_are_ff) << (F + 1)) + NW'(p3_sq_ff);
         p4_dnim_ff <= (NW'(p3_aim_ff) << (F + 1)) + NW'(p3_sq_ff);
         p4_den2_ff <= DW'(p3_sq_ff) << 1;
      end
   end

   // stage 5 (index 0) and bit stages 1..K
   logic                 st_vld_ff     [0:K];
   op_type               st_op_ff      [0:K];
   logic                 st_zero_ff    [0:K];
   logic signed [VW-1:0] st_re_ff      [0:K];
   logic signed [VW-1:0] st_im_ff      [0:K];
   logic                 st_nre_ff     [0:K];
   logic                 st_nim_ff     [0:K];
   logic [DW-1:0]        st_den2_ff    [0:K];
   logic [RW-1:0]        st_dre_rem_ff [0:K];
   logic [RW-1:0]        st_dim_rem_ff [0:K];
   logic [W:0]           st_dre_lo_ff  [0:K];
   logic [W:0]           st_dim_lo_ff  [0:K];
   logic [W:0]           st_dre_q_ff   [0:K];
   logic [W:0]           st_dim_q_ff   [0:K];
   logic                 st_dre_ovf_ff [0:K];
   logic                 st_dim_ovf_ff [0:K];
   logic [XW-1:0]        st_sq_rem_ff  [0:K];
   logic [W:0]           st_sq_r_ff    [0:K];

   logic [NW-1:0] s0_top_re_in, s0_top_im_in;

   assign s0_top_re_in = p4_dnre_ff >> (W + 1);
   assign s0_top_im_in = p4_dnim_ff >> (W + 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_vld_ff[0] <= 1'b0;
      end else if (en) begin
         st_vld_ff[0] <= p4_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_op_ff[0]      <= p4_op_ff;
         st_zero_ff[0]    <= p4_zero_ff;
         st_re_ff[0]      <= p4_re_ff;
         st_im_ff[0]      <= p4_im_ff;
         st_nre_ff[0]     <= p4_nre_ff;
         st_nim_ff[0]     <= p4_nim_ff;
         st_den2_ff[0]    <= p4_den2_ff;
         st_dre_rem_ff[0] <= s0_top_re_in[RW-1:0];
         st_dim_rem_ff[0] <= s0_top_im_in[RW-1:0];
         st_dre_lo_ff[0]  <= p4_dnre_ff[W:0];
         st_dim_lo_ff[0]  <= p4_dnim_ff[W:0];
         st_dre_q_ff[0]   <= '0;
         st_dim_q_ff[0]   <= '0;
         st_dre_ovf_ff[0] <= s0_top_re_in >= NW'(p4_den2_ff);
         st_dim_ovf_ff[0] <= s0_top_im_in >= NW'(p4_den2_ff);
         st_sq_rem_ff[0]  <= p4_sq_ff;
         st_sq_r_ff[0]    <= '0;
      end
   end

   for (genvar k = 0; k < K; k++) begin : g_bit
      localparam int BI = W - k;

      logic [RW-1:0] re_sh_in, im_sh_in, re_rem_in, im_rem_in;
      logic          re_ge_in, im_ge_in, sq_ge_in;
      logic [W:0]    re_q_in, im_q_in, sq_r_in;
      logic [TW-1:0] sq_trial_in;
      logic [XW-1:0] sq_rem_in;

      always_comb begin
         re_sh_in  = {st_dre_rem_ff[k][RW-2:0], st_dre_lo_ff[k][BI]};
         im_sh_in  = {st_dim_rem_ff[k][RW-2:0], st_dim_lo_ff[k][BI]};
         re_ge_in  = re_sh_in >= RW'(st_den2_ff[k]);
         im_ge_in  = im_sh_in >= RW'(st_den2_ff[k]);
         re_rem_in = re_ge_in ? re_sh_in - RW'(st_den2_ff[k]) : re_sh_in;
         im_rem_in = im_ge_in ? im_sh_in - RW'(st_den2_ff[k]) : im_sh_in;
         re_q_in   = st_dre_q_ff[k];
         im_q_in   = st_dim_q_ff[k];
         re_q_in[BI] = re_ge_in;
         im_q_in[BI] = im_ge_in;

         sq_trial_in = (TW'(st_sq_r_ff[k]) << (BI + 1)) + (TW'(1) << (2 * BI));
         sq_ge_in    = TW'(st_sq_rem_ff[k]) >= sq_trial_in;
         sq_rem_in   = sq_ge_in ? XW'(TW'(st_sq_rem_ff[k]) - sq_trial_in)
                                : st_sq_rem_ff[k];
         sq_r_in     = st_sq_r_ff[k];
         sq_r_in[BI] = sq_ge_in;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            st_vld_ff[k+1] <= st_vld_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_op_ff[k+1]      <= st_op_ff[k];
            st_zero_ff[k+1]    <= st_zero_ff[k];
            st_re_ff[k+1]      <= st_re_ff[k];
            st_im_ff[k+1]      <= st_im_ff[k];
            st_nre_ff[k+1]     <= st_nre_ff[k];
            st_nim_ff[k+1]     <= st_nim_ff[k];
            st_den2_ff[k+1]    <= st_den2_ff[k];
            st_dre_rem_ff[k+1] <= re_rem_in;
            st_dim_rem_ff[k+1] <= im_rem_in;
            st_dre_lo_ff[k+1]  <= st_dre_lo_ff[k];
            st_dim_lo_ff[k+1]  <= st_dim_lo_ff[k];
            st_dre_q_ff[k+1]   <= re_q_in;
            st_dim_q_ff[k+1]   <= im_q_in;
            st_dre_ovf_ff[k+1] <= st_dre_ovf_ff[k];
            st_dim_ovf_ff[k+1] <= st_dim_ovf_ff[k];
            st_sq_rem_ff[k+1]  <= sq_rem_in;
            st_sq_r_ff[k+1]    <= sq_r_in;
         end
      end
   end

   // output stage: sign, root rounding, saturation
   logic signed [W-1:0]  out_re_ff, out_im_ff;
   status_type           out_st_ff, out_st_in;
   logic signed [VW-1:0] fin_dre_in, fin_dim_in, fin_re_in, fin_im_in;
   logic [W:0]           fin_root_in, fin_sre_in, fin_sim_in;
   logic                 fin_divz_in;

   always_comb begin
      fin_dre_in = st_dre_ovf_ff[K] ? (VW'(1) <<< (W + 1)) : $signed(VW'(st_dre_q_ff[K]));
      fin_dim_in = st_dim_ovf_ff[K] ? (VW'(1) <<< (W + 1)) : $signed(VW'(st_dim_q_ff[K]));
      if (st_nre_ff[K]) begin
         fin_dre_in = -fin_dre_in;
      end
      if (st_nim_ff[K]) begin
         fin_dim_in = -fin_dim_in;
      end
      fin_root_in = (st_sq_rem_ff[K] > XW'(st_sq_r_ff[K])) ? (W+1)'(st_sq_r_ff[K] + 1'b1)
                                                          : st_sq_r_ff[K];
      fin_divz_in = 1'b0;
      case (st_op_ff[K])
         OP_DIV: begin
            fin_divz_in = st_zero_ff[K];
            fin_re_in   = st_zero_ff[K] ? '0 : fin_dre_in;
            fin_im_in   = st_zero_ff[K] ? '0 : fin_dim_in;
         end
         OP_MAG: begin
            fin_re_in = $signed(VW'(fin_root_in));
            fin_im_in = '0;
         end
         default: begin
            fin_re_in = st_re_ff[K];
            fin_im_in = st_im_ff[K];
         end
      endcase
      fin_sre_in = sat_word(fin_re_in);
      fin_sim_in = sat_word(fin_im_in);
      if (fin_divz_in) begin
         out_st_in = ST_DIVZ;
      end else if (fin_sre_in[W] | fin_sim_in[W]) begin
         out_st_in = ST_SAT;
      end else begin
         out_st_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= st_vld_ff[K];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_re_ff <= fin_sre_in[W-1:0];
         out_im_ff <= fin_sim_in[W-1:0];
         out_st_ff <= out_st_in;
      end
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_result_re = out_re_ff;
   assign rsp_result_im = out_im_ff;
   assign rsp_status    = out_st_ff;

   a_divz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_DIVZ |-> rsp_result_re == '0 && rsp_result_im == '0)
      else $error("divide by zero item carries a nonzero value");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      st_vld_ff[K] && st_op_ff[K] == OP_DIV && !st_zero_ff[K] && !st_dre_ovf_ff[K]
      |-> st_dre_rem_ff[K] < RW'(st_den2_ff[K]))
      else $error("divider remainder not below divisor");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

// ===== tb/sv/tb_complex_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the complex arithmetic unit with a Q16.16 predictor.
module tb_complex_arithmetic_unit;
   import cau_pkg::*;

   localparam int FB = FRAC_BITS_DEF;
   localparam int WB = WORD_BITS_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = WB + 10;

   typedef logic signed [WB-1:0] word_type;
   typedef logic signed [127:0] wide_type;
   typedef logic [127:0] uwide_type;

   typedef struct {
      word_type   re;
      word_type   im;
      status_type st;
   } cplx_result_type;

   class cplx_scoreboard;
      cplx_result_type pending_results[$];
      int errors = 0;

      function word_type clamp(input wide_type v, inout bit sat);
         wide_type hi, lo;
         hi = (wide_type'(1) <<< (WB - 1)) - 1;
         lo = -(wide_type'(1) <<< (WB - 1));
         if (v > hi) begin
            sat = 1;
            return word_type'(hi);
         end
         if (v < lo) begin
            sat = 1;
            return word_type'(lo);
         end
         return word_type'(v);
      endfunction

      function wide_type round_prod(input wide_type v);
         return (v + (wide_type'(1) <<< (FB - 1))) >>> FB;
      endfunction

      function wide_type div_round(input wide_type num, input uwide_type den);
         uwide_type mag, q;
         mag = (num < 0) ? uwide_type'(-num) : uwide_type'(num);
         q = ((mag << (FB + 1)) + den) / (den << 1);
         return (num < 0) ? -wide_type'(q) : wide_type'(q);
      endfunction

      function wide_type sqrt_round(input uwide_type x);
         uwide_type r, t, rem;
         r = 0;
         for (int i = 40; i >= 0; i--) begin
            t = r | (uwide_type'(1) << i);
            if (t * t <= x) r = t;
         end
         rem = x - r * r;
         if (r < rem) r = r + 1;
         return wide_type'(r);
      endfunction

      function void note_request(input op_type op, input word_type a, input word_type b,
                                 input word_type c, input word_type d);
         wide_type wa, wb, wc, wd, re, im;
         uwide_type den;
         cplx_result_type res;
         bit sat;
         wa = a; wb = b; wc = c; wd = d;
         re = 0; im = 0; sat = 0;
         case (op)
            OP_ADD: begin re = wa + wc; im = wb + wd; end
            OP_SUB: begin re = wa - wc; im = wb - wd; end
            OP_MUL: begin
               re = round_prod(wa * wc - wb * wd);
               im = round_prod(wa * wd + wc * wb);
            end
            OP_DIV: begin
               den = uwide_type'(wc * wc + wd * wd);
               if (den == 0) begin
                  res.re = 0; res.im = 0; res.st = ST_DIVZ;
                  pending_results.push_back(res);
                  return;
               end
               re = div_round(wa * wc + wb * wd, den);
               im = div_round(wc * wb - wa * wd, den);
            end
            OP_CONJ: begin re = wa; im = -wb; end
            OP_NEG: begin re = -wa; im = -wb; end
            OP_SQMAG: re = round_prod(wa * wa + wb * wb);
            default: re = sqrt_round(uwide_type'(wa * wa + wb * wb));
         endcase
         res.re = clamp(re, sat);
         res.im = clamp(im, sat);
         res.st = sat ? ST_SAT : ST_OK;
         pending_results.push_back(res);
      endfunction

      task report(input string what, input logic [WB-1:0] got, input logic [WB-1:0] want);
         $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
         errors++;
      endtask

      task check_result(input word_type re, input word_type im, input logic [1:0] st);
         cplx_result_type exp_res;
         if (pending_results.size() == 0) begin
            report("unexpected item", re, 0);
            return;
         end
         exp_res = pending_results.pop_front();
         if (re !== exp_res.re) report("result_re", re, exp_res.re);
         if (im !== exp_res.im) report("result_im", im, exp_res.im);
         if (st !== exp_res.st) report("status", WB'(st), WB'(exp_res.st));
      endtask
   endclass

   logic clock = 0;
   logic reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   logic [2:0] req_operation;
   word_type req_first_re, req_first_im, req_second_re, req_second_im;
   word_type rsp_result_re, rsp_result_im;
   logic [1:0] rsp_status;
   bit quiet = 0;
   int cycles = 0;
   cplx_scoreboard sb = new();

   complex_arithmetic_unit u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_operation(req_operation),
      .req_first_re(req_first_re), .req_first_im(req_first_im),
      .req_second_re(req_second_re), .req_second_im(req_second_im),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_re(rsp_result_re), .rsp_result_im(rsp_result_im),
      .rsp_status(rsp_status)
   );

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_complex_arithmetic_unit NOT OK");
         $finish;
      end
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(op_type'(req_operation), req_first_re, req_first_im,
                            req_second_re, req_second_im);
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_result_re, rsp_result_im, rsp_status);
      end
   end

   initial begin
      int gap;
      rsp_ready <= 0;
      @(negedge reset);
      forever begin
         gap = quiet ? 0 : $urandom_range(0, 7);
         if (gap > 0) begin
            rsp_ready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task send_item(input op_type op, input word_type a, input word_type b,
                  input word_type c, input word_type d);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_operation <= op;
      req_first_re <= a;
      req_first_im <= b;
      req_second_re <= c;
      req_second_im <= d;
      req_valid <= 1;
      do @(posedge clock); while (!req_ready);
   endtask

   function word_type rand_word();
      case ($urandom_range(0, 5))
         0: return word_type'($urandom);
         1: return word_type'($urandom_range(0, 3)) - 1 +
                   ($urandom_range(0, 1) ? 32'h8000_0000 : 0);
         2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
         3: return word_type'($urandom_range(0, 4095)) - 2048;
         default: return word_type'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      endcase
   endfunction

   initial begin
      word_type mx, mn, c, d;
      op_type op;
      mx = 32'h7fff_ffff;
      mn = 32'h8000_0000;
      reset <= 1;
      req_valid <= 0;
      req_operation <= OP_ADD;
      req_first_re <= 0; req_first_im <= 0;
      req_second_re <= 0; req_second_im <= 0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      for (int k = 0; k < 8; k++) send_item(op_type'(k), mx, mn, mx, mn);
      for (int k = 0; k < 8; k++) send_item(op_type'(k), mn, mn, mn, mx);
      send_item(OP_DIV, 32'h0001_0000, 32'h0002_0000, 0, 0);
      send_item(OP_NEG, mn, 0, 5, 5);
      send_item(OP_MUL, 1, 0, 32'h8000, 0);
      send_item(OP_MUL, -1, 0, 32'h8000, 0);
      send_item(OP_DIV, 1, 0, 32'h0002_0000, 0);
      send_item(OP_DIV, -1, 0, 32'h0002_0000, 0);
      send_item(OP_MAG, 32'h0003_0000, 32'h0004_0000, mx, mx);
      send_item(OP_MAG, 3, 0, 0, 0);

      for (int n = 0; n < 500; n++) begin
         if (n == 250) begin
            req_valid <= 0;
            do @(posedge clock); while (sb.pending_results.size() != 0);
         end
         if (n % 100 == 0) quiet = (n == 100 || n == 400);
         op = op_type'($urandom_range(0, 7));
         c = rand_word();
         d = rand_word();
         if (op == OP_DIV && $urandom_range(0, 15) == 0) begin
            c = 0;
            d = 0;
         end
         send_item(op, rand_word(), rand_word(), c, d);
      end
      req_valid <= 0;
      quiet = 0;
      do @(posedge clock); while (sb.pending_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending_results.size() == 0)
         $display("tb_complex_arithmetic_unit OK");
      else
         $display("tb_complex_arithmetic_unit NOT OK");
      $finish;
   end
endmodule
